// File: rtl/core/ismu_pkg.sv
// ismu_pkg: shared types and constants of the ising metropolis spin update core
// field widths, opcodes, configuration register indexes and the decision record
// no dependencies
`default_nettype none

package ismu_pkg;

	// fixed field widths of the ports and of the threshold entries
	localparam int SITE_FIELD_W = 12;
	localparam int SLOT_FIELD_W = 3;
	localparam int RAND_FIELD_W = 16;
	localparam int THR_W        = 16;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 2;

	// neighbour sum spans -8..8, energy change spans -16..16
	localparam int SUM_W = 5;
	localparam int DE_W  = SUM_W + 1;

	// site index reduction: compare-subtract steps per cycle and cycles
	localparam int WRAP_STEPS  = 4;
	localparam int WRAP_CYCLES = SITE_FIELD_W / WRAP_STEPS;

	typedef enum logic [1:0] {
		OP_WRITE_NBR  = 2'd0,
		OP_WRITE_SPIN = 2'd1,
		OP_READ_SPIN  = 2'd2,
		OP_UPDATE     = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUPLING = 2'd0,
		CFG_ACC_LOW  = 2'd1,
		CFG_ACC_HIGH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                   flip;
		logic signed [DE_W-1:0] de;
	} decide_t;

endpackage

`default_nettype wire

// File: rtl/core/ismu_site_wrap.sv
// ismu_site_wrap: reduces the site and neighbour indices modulo SITES
// restoring remainder, WRAP_STEPS compare-subtract steps per cycle
// depends on ismu_pkg
`default_nettype none

module ismu_site_wrap #(
	parameter int SITES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [ismu_pkg::SITE_FIELD_W-1:0] site_in,
	input  logic [ismu_pkg::SITE_FIELD_W-1:0] nbr_in,
	output logic [ismu_pkg::SITE_FIELD_W-1:0] site_out,
	output logic [ismu_pkg::SITE_FIELD_W-1:0] nbr_out,
	output logic                             done
);
	import ismu_pkg::*;

	localparam int  CYC_W      = $clog2(WRAP_CYCLES + 1);
	localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(WRAP_CYCLES - 1);
	localparam longint FIELD_MAX = (longint'(1) << SITE_FIELD_W) - 1;

	logic [SITE_FIELD_W-1:0] site_q, nbr_q, site_nx, nbr_nx;
	logic [CYC_W-1:0]        cyc_q;
	logic                    run_q, done_q;

	// divisor SITES << k, top bit set when it exceeds the field range
	function automatic logic [SITE_FIELD_W:0] divisor_at(input int k);
		longint d;
		d = longint'(SITES) << k;
		if (d > FIELD_MAX)
			divisor_at = {1'b1, {SITE_FIELD_W{1'b0}}};
		else
			divisor_at = {1'b0, SITE_FIELD_W'(d)};
	endfunction

	always_comb begin
		int                  k;
		logic [SITE_FIELD_W:0] d;
		site_nx = site_q;
		nbr_nx  = nbr_q;
		for (int j = 0; j < WRAP_STEPS; j++) begin
			k = SITE_FIELD_W - 1 - WRAP_STEPS * int'(cyc_q) - j;
			d = divisor_at(k);
			if (!d[SITE_FIELD_W] && site_nx >= d[SITE_FIELD_W-1:0])
				site_nx = site_nx - d[SITE_FIELD_W-1:0];
			if (!d[SITE_FIELD_W] && nbr_nx >= d[SITE_FIELD_W-1:0])
				nbr_nx = nbr_nx - d[SITE_FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= run_q && (cyc_q == CYC_LAST);
			if (load) begin
				run_q <= 1'b1;
				cyc_q <= '0;
			end else if (run_q) begin
				cyc_q <= cyc_q + CYC_W'(1);
				if (cyc_q == CYC_LAST)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			site_q <= site_in;
			nbr_q  <= nbr_in;
		end else if (run_q) begin
			site_q <= site_nx;
			nbr_q  <= nbr_nx;
		end
	end

	assign site_out = site_q;
	assign nbr_out  = nbr_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: rtl/core/ismu_nbr_table.sv
// ismu_nbr_table: neighbour table memory, one write and one read port
// registered read data, no reset of the contents
// no package dependencies
`default_nettype none

module ismu_nbr_table #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 13
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/ismu_spin_store.sv
// ismu_spin_store: one-bit spin memory with registered read
// sweeps every entry to +1 after reset, ignoring write requests until the sweep ends
// no package dependencies
`default_nettype none

module ismu_spin_store #(
	parameter int SITES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(SITES)-1:0] wr_addr,
	input  logic                     wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(SITES)-1:0] rd_addr,
	output logic                     rd_data,
	output logic                     clearing
);
	localparam int SITE_W = $clog2(SITES);
	localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITES - 1);

	logic              mem [SITES];
	logic              rd_data_q;
	logic              clearing_q;
	logic [SITE_W-1:0] clr_cnt_q;
	logic              we;
	logic [SITE_W-1:0] wa;
	logic              wd;

	// the clearing pass owns the write port until it ends
	always_comb begin
		we = wr_en;
		wa = wr_addr;
		wd = wr_data;
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + SITE_W'(1);
			if (clr_cnt_q == LAST_SITE)
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

// File: rtl/core/ismu_decide.sv
// ismu_decide: energy change and metropolis acceptance for one site
// picks the threshold for DE and compares it with the random fraction
// depends on ismu_pkg
`default_nettype none

module ismu_decide #(
	parameter int RAND_BITS = 16
) (
	input  logic signed [ismu_pkg::SUM_W-1:0]   sum,
	input  logic                                spin,
	input  logic                                coupling_negative,
	input  logic [ismu_pkg::CFG_W-1:0]          accept_low,
	input  logic [ismu_pkg::CFG_W-1:0]          accept_high,
	input  logic [ismu_pkg::RAND_FIELD_W-1:0]   rnd,
	output ismu_pkg::decide_t                   res
);
	import ismu_pkg::*;

	localparam int CMP_W = THR_W + RAND_BITS;
	localparam logic [RAND_FIELD_W-1:0] RND_MASK = (RAND_BITS >= RAND_FIELD_W) ?
		{RAND_FIELD_W{1'b1}} : RAND_FIELD_W'((longint'(1) << RAND_BITS) - 1);

	logic signed [SUM_W-1:0] p;
	logic                    positive;
	logic [2:0]              k;
	logic [CFG_W-1:0]        word;
	logic [THR_W-1:0]        thr;
	logic [CMP_W-1:0]        thr_al, rnd_al;
	logic                    accept;

	always_comb begin
		// j*s is -1 when exactly one of coupling and spin is negative
		p        = (coupling_negative ^ ~spin) ? -sum : sum;
		positive = !p[SUM_W-1] && (p != '0);
		k        = 3'(p - SUM_W'(1));
		word     = k[2] ? accept_high : accept_low;
		thr      = word[k[1:0]*THR_W +: THR_W];
		// both sides on a common Q0.(16+RAND_BITS) scale
		thr_al   = {thr, {RAND_BITS{1'b0}}};
		rnd_al   = CMP_W'(rnd & RND_MASK) << THR_W;
		accept   = thr_al >= rnd_al;
		res.flip = !positive || accept;
		res.de   = {p, 1'b0};
	end

endmodule

`default_nettype wire

// File: rtl/core/ising_metropolis_spin_update_core.sv
// ising_metropolis_spin_update_core: top level, command sequencer and config registers
// instantiates ismu_site_wrap, ismu_nbr_table, ismu_spin_store and ismu_decide
// depends on ismu_pkg
`default_nettype none

// Ising spin store with Metropolis single-spin-flip updates on an arbitrary graph.
// A command is taken at a clock edge where start is high and busy is low; its one
// result appears on spin_out, flipped and energy_change for exactly one cycle,
// marked by done, and the receiver cannot stall it. Commands run one at a time:
// each passes index reduction modulo SITES and a site access, and an update then
// walks the neighbour slots serially (one neighbour-table read and one spin-memory
// read per cycle, pipelined two deep) before its decision and flipped-spin write.
// busy drops in the done cycle, so the next command can be taken at its end.
// After reset the spin memory is swept to +1 with busy high; configuration writes
// are taken throughout, but only while no command is in flight is their effect
// defined. Neighbour slots must be written before an update reads them.
module ising_metropolis_spin_update_core #(
	parameter int SITES      = 4096,
	parameter int NEIGHBOURS = 8,
	parameter int RAND_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [ismu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ismu_pkg::CFG_W-1:0]            cfg_data,
	// command beat
	input  logic                                  start,
	output logic                                  busy,
	input  ismu_pkg::opcode_t                     opcode,
	input  logic [ismu_pkg::SITE_FIELD_W-1:0]     site,
	input  logic [ismu_pkg::SLOT_FIELD_W-1:0]     slot,
	input  logic [ismu_pkg::SITE_FIELD_W-1:0]     neighbour_site,
	input  logic                                  neighbour_present,
	input  logic                                  spin_in,
	input  logic [ismu_pkg::RAND_FIELD_W-1:0]     random_fraction,
	// result beat
	output logic                                  done,
	output logic                                  spin_out,
	output logic                                  flipped,
	output logic signed [ismu_pkg::DE_W-1:0]      energy_change
);
	import ismu_pkg::*;

	localparam int SITE_W  = $clog2(SITES);
	localparam int SLOT_W  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
	localparam int ADDR_W  = SITE_W + SLOT_W;
	localparam int ENTRY_W = SITE_W + 1;
	localparam int CNT_W   = $clog2(NEIGHBOURS + 2);
	localparam logic [CNT_W-1:0] WALK_LAST  = CNT_W'(NEIGHBOURS + 1);
	localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(NEIGHBOURS);
	localparam logic [SLOT_FIELD_W:0] SLOT_LIMIT = (SLOT_FIELD_W + 1)'(NEIGHBOURS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_WRAP   = 6'b000010,
		S_SITE   = 6'b000100,
		S_WALK   = 6'b001000,
		S_DECIDE = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	// captured command fields
	opcode_t                 op_q;
	logic [SLOT_FIELD_W-1:0] slot_q;
	logic                    pres_q;
	logic                    spin_in_q;
	logic [RAND_FIELD_W-1:0] rnd_q;

	// configuration registers
	logic             coupling_neg_q;
	logic [CFG_W-1:0] acc_low_q, acc_high_q;

	// reduced indices
	logic [SITE_FIELD_W-1:0] wrap_site, wrap_nbr;
	logic                    wrap_done;
	logic [SITE_W-1:0]       site_w, nsite_w;

	// memory ports
	logic               sp_rd_en, sp_wr_en, sp_wr_data, sp_rd_data, clearing;
	logic [SITE_W-1:0]  sp_rd_addr, sp_wr_addr;
	logic               nt_rd_en, nt_wr_en;
	logic [ADDR_W-1:0]  nt_rd_addr, nt_wr_addr;
	logic [ENTRY_W-1:0] nt_rd_data, nt_wr_data;
	logic               nt_present;
	logic [SITE_W-1:0]  nt_index;

	// neighbour walk
	logic [CNT_W-1:0]        cnt_q;
	logic                    tbl_vld_s1, spn_vld_s2;
	logic signed [SUM_W-1:0] sum_q;
	logic                    spin_site_q;
	decide_t                 dec;
	logic                    slot_ok, accept;

	// result registers
	logic                   done_q, spin_out_q, flipped_q;
	logic signed [DE_W-1:0] de_q;

	assign busy    = (state_q != S_IDLE) || clearing;
	assign accept  = start && !busy;
	assign site_w  = SITE_W'(wrap_site);
	assign nsite_w = SITE_W'(wrap_nbr);
	assign slot_ok = {1'b0, slot_q} < SLOT_LIMIT;

	// stored entries hold already reduced indices
	assign nt_present = nt_rd_data[ENTRY_W-1];
	assign nt_index   = nt_rd_data[SITE_W-1:0];

	ismu_site_wrap #(
		.SITES(SITES)
	) u_wrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.site_in (site),
		.nbr_in  (neighbour_site),
		.site_out(wrap_site),
		.nbr_out (wrap_nbr),
		.done    (wrap_done)
	);

	ismu_nbr_table #(
		.ADDR_W(ADDR_W),
		.DATA_W(ENTRY_W)
	) u_nbr (
		.clk    (clk),
		.wr_en  (nt_wr_en),
		.wr_addr(nt_wr_addr),
		.wr_data(nt_wr_data),
		.rd_en  (nt_rd_en),
		.rd_addr(nt_rd_addr),
		.rd_data(nt_rd_data)
	);

	ismu_spin_store #(
		.SITES(SITES)
	) u_spin (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sp_wr_en),
		.wr_addr (sp_wr_addr),
		.wr_data (sp_wr_data),
		.rd_en   (sp_rd_en),
		.rd_addr (sp_rd_addr),
		.rd_data (sp_rd_data),
		.clearing(clearing)
	);

	ismu_decide #(
		.RAND_BITS(RAND_BITS)
	) u_decide (
		.sum              (sum_q),
		.spin             (spin_site_q),
		.coupling_negative(coupling_neg_q),
		.accept_low       (acc_low_q),
		.accept_high      (acc_high_q),
		.rnd              (rnd_q),
		.res              (dec)
	);

	// memory request steering
	always_comb begin
		sp_rd_en   = 1'b0;
		sp_rd_addr = site_w;
		sp_wr_en   = 1'b0;
		sp_wr_addr = site_w;
		sp_wr_data = spin_in_q;
		nt_rd_en   = 1'b0;
		nt_rd_addr = {site_w, cnt_q[SLOT_W-1:0]};
		nt_wr_en   = 1'b0;
		nt_wr_addr = {site_w, slot_q[SLOT_W-1:0]};
		nt_wr_data = {pres_q, nsite_w};
		case (state_q)
			S_SITE: begin
				// site spin is read for every command, the write commands land here too
				sp_rd_en = 1'b1;
				if (op_q == OP_WRITE_NBR && slot_ok)
					nt_wr_en = 1'b1;
				if (op_q == OP_WRITE_SPIN)
					sp_wr_en = 1'b1;
			end
			S_WALK: begin
				// slot k is fetched at count k, its spin in the cycle after
				nt_rd_en = cnt_q < SLOT_COUNT;
				if (tbl_vld_s1 && nt_present) begin
					sp_rd_en   = 1'b1;
					sp_rd_addr = nt_index;
				end
			end
			S_DECIDE: begin
				sp_wr_en   = dec.flip;
				sp_wr_data = ~spin_site_q;
			end
			default: ;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done_q         <= 1'b0;
			cnt_q          <= '0;
			tbl_vld_s1     <= 1'b0;
			spn_vld_s2     <= 1'b0;
			coupling_neg_q <= 1'b1;
			acc_low_q      <= '0;
			acc_high_q     <= '0;
		end else begin
			done_q     <= 1'b0;
			tbl_vld_s1 <= 1'b0;
			spn_vld_s2 <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_COUPLING: coupling_neg_q <= cfg_data[0];
					CFG_ACC_LOW:  acc_low_q      <= cfg_data;
					CFG_ACC_HIGH: acc_high_q     <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (wrap_done)
						state_q <= S_SITE;
				end
				S_SITE: begin
					cnt_q   <= '0;
					state_q <= (op_q == OP_UPDATE) ? S_WALK : S_FINISH;
				end
				S_WALK: begin
					cnt_q      <= cnt_q + CNT_W'(1);
					tbl_vld_s1 <= nt_rd_en;
					spn_vld_s2 <= tbl_vld_s1 && nt_present;
					if (cnt_q == WALK_LAST)
						state_q <= S_DECIDE;
				end
				S_DECIDE, S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: captured command, neighbour sum and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			slot_q    <= slot;
			pres_q    <= neighbour_present;
			spin_in_q <= spin_in;
			rnd_q     <= random_fraction;
		end
		if (state_q == S_SITE)
			sum_q <= '0;
		if (state_q == S_WALK) begin
			// first walk cycle returns the spin of the site itself
			if (cnt_q == '0)
				spin_site_q <= sp_rd_data;
			if (spn_vld_s2)
				sum_q <= sp_rd_data ? sum_q + SUM_W'(1) : sum_q - SUM_W'(1);
		end
		if (state_q == S_FINISH) begin
			spin_out_q <= (op_q == OP_WRITE_SPIN) ? spin_in_q : sp_rd_data;
			flipped_q  <= 1'b0;
			de_q       <= '0;
		end
		if (state_q == S_DECIDE) begin
			spin_out_q <= spin_site_q ^ dec.flip;
			flipped_q  <= dec.flip;
			de_q       <= dec.de;
		end
	end

	assign done          = done_q;
	assign spin_out      = spin_out_q;
	assign flipped       = flipped_q;
	assign energy_change = de_q;

endmodule

`default_nettype wire

// File: rtl/core/ismu_checker.sv
// ismu_checker: port-level assertions for the spin update core
// bound to ising_metropolis_spin_update_core, depends on ismu_pkg
`default_nettype none

module ismu_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic                              flipped,
	input logic signed [ismu_pkg::DE_W-1:0]  energy_change
);
	import ismu_pkg::*;

	// results never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in consecutive cycles");

	// a taken command holds the block busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a command was taken");

	// the result cycle already frees the command side
	a_free_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy high during the result beat");

	// a result without a flip never carries a negative energy change
	a_reject_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !flipped) |-> !energy_change[DE_W-1])
		else $error("spin kept although energy change is negative");

	// energy change is plus or minus twice the neighbour sum, so always even
	a_de_even: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !energy_change[0])
		else $error("odd energy change");

endmodule

bind ising_metropolis_spin_update_core ismu_checker u_ismu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.flipped      (flipped),
	.energy_change(energy_change)
);

`default_nettype wire
